>>> rtl/mpmv_pkg.sv
// shared types, constants and register indexes for the grid node velocity update
package mpmv_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int COORD_BITS    = 10;
    localparam int WORD_BITS     = 32;
    localparam int GRID_BITS     = COORD_BITS + 1;
    localparam int WALL_BITS     = 5;
    localparam int SUM_BITS      = COORD_BITS + 2;
    localparam int DIV_W         = WORD_BITS + FRACTION_BITS;
    localparam int DIV_STAGES    = DIV_W;
    localparam int CFG_IDX_BITS  = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WALL_THICKNESS = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRAVITY_STEP   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_MASS       = 3'd4;

    localparam logic [GRID_BITS-1:0] RST_GRID_WIDTH     = 11'd128;
    localparam logic [GRID_BITS-1:0] RST_GRID_HEIGHT    = 11'd128;
    localparam logic [WALL_BITS-1:0] RST_WALL_THICKNESS = 5'd2;
    localparam logic [WORD_BITS-1:0] RST_GRAVITY_STEP   = 32'd0;
    localparam logic [WORD_BITS-1:0] RST_MIN_MASS       = 32'd1;

    typedef struct packed {
        logic [GRID_BITS-1:0]        grid_width;
        logic [GRID_BITS-1:0]        grid_height;
        logic [WALL_BITS-1:0]        wall_thickness;
        logic signed [WORD_BITS-1:0] gravity_step;
        logic [WORD_BITS-1:0]        min_mass;
    } cfg_t;

    typedef struct packed {
        logic empty;
        logic neg_x;
        logic neg_y;
        logic wall_l;
        logic wall_r;
        logic wall_b;
        logic wall_t;
    } side_t;

    // partial remainder plus a word that shifts dividend bits out and quotient bits in
    typedef struct packed {
        logic [WORD_BITS-1:0] rem;
        logic [DIV_W-1:0]     dq;
    } div_lane_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] mass;
        div_lane_t            lane_x;
        div_lane_t            lane_y;
        side_t                side;
    } div_word_t;

endpackage

>>> rtl/mpmv_prep.sv
// input cell: magnitudes, empty test and wall flags for one node
module mpmv_prep (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [mpmv_pkg::COORD_BITS-1:0]       col,
    input  logic [mpmv_pkg::COORD_BITS-1:0]       row,
    input  logic [mpmv_pkg::WORD_BITS-1:0]        node_mass,
    input  logic signed [mpmv_pkg::WORD_BITS-1:0] momentum_x,
    input  logic signed [mpmv_pkg::WORD_BITS-1:0] momentum_y,
    input  mpmv_pkg::cfg_t                        cfg,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output mpmv_pkg::div_word_t                   out_word
);

    logic                valid_reg, valid_next;
    mpmv_pkg::div_word_t word_reg, word_next;
    logic [mpmv_pkg::WORD_BITS-1:0] mag_x, mag_y;
    logic [mpmv_pkg::SUM_BITS-1:0]  col_ext, row_ext, wt_ext, col_sum, row_sum;
    logic [mpmv_pkg::SUM_BITS-1:0]  gw_ext, gh_ext;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        mag_x   = momentum_x[mpmv_pkg::WORD_BITS-1] ? (~momentum_x + 1'b1) : momentum_x;
        mag_y   = momentum_y[mpmv_pkg::WORD_BITS-1] ? (~momentum_y + 1'b1) : momentum_y;
        col_ext = mpmv_pkg::SUM_BITS'(col);
        row_ext = mpmv_pkg::SUM_BITS'(row);
        wt_ext  = mpmv_pkg::SUM_BITS'(cfg.wall_thickness);
        gw_ext  = mpmv_pkg::SUM_BITS'(cfg.grid_width);
        gh_ext  = mpmv_pkg::SUM_BITS'(cfg.grid_height);
        col_sum = col_ext + wt_ext;
        row_sum = row_ext + wt_ext;

        word_next                = word_reg;
        word_next.mass           = node_mass;
        word_next.lane_x.rem     = '0;
        word_next.lane_x.dq      = {mag_x, {mpmv_pkg::FRACTION_BITS{1'b0}}};
        word_next.lane_y.rem     = '0;
        word_next.lane_y.dq      = {mag_y, {mpmv_pkg::FRACTION_BITS{1'b0}}};
        word_next.side.empty     = (node_mass == '0) || (node_mass < cfg.min_mass);
        word_next.side.neg_x     = momentum_x[mpmv_pkg::WORD_BITS-1];
        word_next.side.neg_y     = momentum_y[mpmv_pkg::WORD_BITS-1];
        word_next.side.wall_l    = col_ext < wt_ext;
        word_next.side.wall_r    = col_sum >= gw_ext;
        word_next.side.wall_b    = row_ext < wt_ext;
        word_next.side.wall_t    = row_sum >= gh_ext;

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

>>> rtl/mpmv_div_cell.sv
// divider cell: one restoring quotient bit for both momentum lanes
module mpmv_div_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  mpmv_pkg::div_word_t in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output mpmv_pkg::div_word_t out_word
);

    logic                valid_reg, valid_next;
    mpmv_pkg::div_word_t word_reg, word_next;

    function automatic mpmv_pkg::div_lane_t div_step(
        input mpmv_pkg::div_lane_t       lane,
        input logic [mpmv_pkg::WORD_BITS-1:0] mass
    );
        logic [mpmv_pkg::WORD_BITS:0] trial;
        logic [mpmv_pkg::WORD_BITS:0] diff;
        logic                         take;
        mpmv_pkg::div_lane_t          res;
        trial = {lane.rem, lane.dq[mpmv_pkg::DIV_W-1]};
        diff  = trial - {1'b0, mass};
        take  = trial >= {1'b0, mass};
        res.rem = take ? diff[mpmv_pkg::WORD_BITS-1:0] : trial[mpmv_pkg::WORD_BITS-1:0];
        res.dq  = {lane.dq[mpmv_pkg::DIV_W-2:0], take};
        return res;
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        word_next        = in_word;
        word_next.lane_x = div_step(in_word.lane_x, in_word.mass);
        word_next.lane_y = div_step(in_word.lane_y, in_word.mass);
        valid_next       = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

>>> rtl/mpmv_post.sv
// output cells: sign and saturation, then gravity, walls, empty override and result register
module mpmv_post (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  mpmv_pkg::div_word_t                   in_word,
    input  logic signed [mpmv_pkg::WORD_BITS-1:0] gravity_step,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [mpmv_pkg::WORD_BITS-1:0] velocity_x,
    output logic signed [mpmv_pkg::WORD_BITS-1:0] velocity_y,
    output logic                                  node_empty
);

    localparam logic [mpmv_pkg::WORD_BITS-1:0] SMAX = {1'b0, {(mpmv_pkg::WORD_BITS-1){1'b1}}};
    localparam logic [mpmv_pkg::WORD_BITS-1:0] SMIN = {1'b1, {(mpmv_pkg::WORD_BITS-1){1'b0}}};

    logic                                  a_valid_reg, a_valid_next, a_ready;
    logic signed [mpmv_pkg::WORD_BITS-1:0] a_vx_reg, a_vx_next;
    logic signed [mpmv_pkg::WORD_BITS-1:0] a_vy_reg, a_vy_next;
    mpmv_pkg::side_t                       a_side_reg;

    logic                                  b_valid_reg, b_valid_next;
    logic signed [mpmv_pkg::WORD_BITS-1:0] b_vx_reg, b_vx_next;
    logic signed [mpmv_pkg::WORD_BITS-1:0] b_vy_reg, b_vy_next;
    logic                                  b_empty_reg;

    logic signed [mpmv_pkg::WORD_BITS:0]   vy_sum;
    logic signed [mpmv_pkg::WORD_BITS-1:0] vy_grav;

    function automatic logic [mpmv_pkg::WORD_BITS-1:0] sat_quot(
        input logic [mpmv_pkg::DIV_W-1:0] q,
        input logic                       neg
    );
        logic high_set;
        logic [mpmv_pkg::WORD_BITS-1:0] res;
        high_set = |q[mpmv_pkg::DIV_W-1:mpmv_pkg::WORD_BITS];
        if (neg) begin
            if (high_set || (q[mpmv_pkg::WORD_BITS-1] && (|q[mpmv_pkg::WORD_BITS-2:0]))) begin
                res = SMIN;
            end else begin
                res = ~q[mpmv_pkg::WORD_BITS-1:0] + 1'b1;
            end
        end else begin
            if (high_set || q[mpmv_pkg::WORD_BITS-1]) begin
                res = SMAX;
            end else begin
                res = q[mpmv_pkg::WORD_BITS-1:0];
            end
        end
        return res;
    endfunction

    // stage a: quotient to signed velocity
    assign in_ready = !a_valid_reg || a_ready;

    always_comb begin
        a_vx_next    = sat_quot(in_word.lane_x.dq, in_word.side.neg_x);
        a_vy_next    = sat_quot(in_word.lane_y.dq, in_word.side.neg_y);
        a_valid_next = in_ready ? in_valid : a_valid_reg;
    end

    // stage b: gravity with saturation, sticky walls, empty override
    assign a_ready = !b_valid_reg || out_ready;

    always_comb begin
        vy_sum = {a_vy_reg[mpmv_pkg::WORD_BITS-1], a_vy_reg}
               + {gravity_step[mpmv_pkg::WORD_BITS-1], gravity_step};
        if (vy_sum[mpmv_pkg::WORD_BITS] != vy_sum[mpmv_pkg::WORD_BITS-1]) begin
            vy_grav = vy_sum[mpmv_pkg::WORD_BITS] ? SMIN : SMAX;
        end else begin
            vy_grav = vy_sum[mpmv_pkg::WORD_BITS-1:0];
        end

        b_vx_next = a_vx_reg;
        if (a_side_reg.wall_l && a_vx_reg < 0) begin
            b_vx_next = '0;
        end
        if (a_side_reg.wall_r && a_vx_reg > 0) begin
            b_vx_next = '0;
        end
        b_vy_next = vy_grav;
        if (a_side_reg.wall_b && vy_grav < 0) begin
            b_vy_next = '0;
        end
        if (a_side_reg.wall_t && vy_grav > 0) begin
            b_vy_next = '0;
        end
        if (a_side_reg.empty) begin
            b_vx_next = '0;
            b_vy_next = '0;
        end
        b_valid_next = a_ready ? a_valid_reg : b_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            a_vx_reg   <= a_vx_next;
            a_vy_reg   <= a_vy_next;
            a_side_reg <= in_word.side;
        end
        if (a_valid_reg && a_ready) begin
            b_vx_reg    <= b_vx_next;
            b_vy_reg    <= b_vy_next;
            b_empty_reg <= a_side_reg.empty;
        end
    end

    assign out_valid  = b_valid_reg;
    assign velocity_x = b_vx_reg;
    assign velocity_y = b_vy_reg;
    assign node_empty = b_empty_reg;

endmodule

>>> rtl/mpm_grid_node_velocity_update_unit.sv
// top level: config registers and the chain of cells for the grid node velocity update
// One grid node enters and one result leaves per clock while m_ready stays high. A node passes
// an input cell, a chain of 48 divider cells (one quotient bit each, both momentum components
// side by side, 32 + fraction bits in all) and two output cells, each a register stage. Every
// cell holds its own transaction and moves on as soon as the next cell has room, so gaps close
// up under backpressure and s_ready stays high until the whole chain is full. Configuration
// writes are taken on every cycle and must be made while no node is in flight.
module mpm_grid_node_velocity_update_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [mpmv_pkg::COORD_BITS-1:0]       s_col,
    input  logic [mpmv_pkg::COORD_BITS-1:0]       s_row,
    input  logic [mpmv_pkg::WORD_BITS-1:0]        s_node_mass,
    input  logic signed [mpmv_pkg::WORD_BITS-1:0] s_momentum_x,
    input  logic signed [mpmv_pkg::WORD_BITS-1:0] s_momentum_y,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [mpmv_pkg::WORD_BITS-1:0] m_velocity_x,
    output logic signed [mpmv_pkg::WORD_BITS-1:0] m_velocity_y,
    output logic                                  m_node_empty,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mpmv_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [mpmv_pkg::WORD_BITS-1:0]        cfg_data
);

    mpmv_pkg::cfg_t cfg_reg, cfg_next;

    logic                chain_valid [0:mpmv_pkg::DIV_STAGES];
    logic                chain_ready [0:mpmv_pkg::DIV_STAGES];
    mpmv_pkg::div_word_t chain_word  [0:mpmv_pkg::DIV_STAGES];

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                mpmv_pkg::CFG_GRID_WIDTH: begin
                    cfg_next.grid_width = cfg_data[mpmv_pkg::GRID_BITS-1:0];
                end
                mpmv_pkg::CFG_GRID_HEIGHT: begin
                    cfg_next.grid_height = cfg_data[mpmv_pkg::GRID_BITS-1:0];
                end
                mpmv_pkg::CFG_WALL_THICKNESS: begin
                    cfg_next.wall_thickness = cfg_data[mpmv_pkg::WALL_BITS-1:0];
                end
                mpmv_pkg::CFG_GRAVITY_STEP: begin
                    cfg_next.gravity_step = cfg_data;
                end
                mpmv_pkg::CFG_MIN_MASS: begin
                    cfg_next.min_mass = cfg_data;
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.grid_width     <= mpmv_pkg::RST_GRID_WIDTH;
            cfg_reg.grid_height    <= mpmv_pkg::RST_GRID_HEIGHT;
            cfg_reg.wall_thickness <= mpmv_pkg::RST_WALL_THICKNESS;
            cfg_reg.gravity_step   <= mpmv_pkg::RST_GRAVITY_STEP;
            cfg_reg.min_mass       <= mpmv_pkg::RST_MIN_MASS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mpmv_prep u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .col        (s_col),
        .row        (s_row),
        .node_mass  (s_node_mass),
        .momentum_x (s_momentum_x),
        .momentum_y (s_momentum_y),
        .cfg        (cfg_reg),
        .out_valid  (chain_valid[0]),
        .out_ready  (chain_ready[0]),
        .out_word   (chain_word[0])
    );

    for (genvar i = 0; i < mpmv_pkg::DIV_STAGES; i++) begin : g_cell
        mpmv_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_word   (chain_word[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_word  (chain_word[i+1])
        );
    end

    mpmv_post u_post (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (chain_valid[mpmv_pkg::DIV_STAGES]),
        .in_ready     (chain_ready[mpmv_pkg::DIV_STAGES]),
        .in_word      (chain_word[mpmv_pkg::DIV_STAGES]),
        .gravity_step (cfg_reg.gravity_step),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .velocity_x   (m_velocity_x),
        .velocity_y   (m_velocity_y),
        .node_empty   (m_node_empty)
    );

    // empty nodes never carry a velocity
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_node_empty |-> m_velocity_x == '0 && m_velocity_y == '0)
        else $error("empty node with nonzero velocity");

    // no result right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a node just taken always lands in the input cell
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> chain_valid[0])
        else $error("accepted node lost at the input cell");

endmodule
